/* sv/thb_alu_pkg.sv */
package thb_alu_pkg;

	// thumb format 4 alu opcodes
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_LSL = 4'd2,
		OP_LSR = 4'd3,
		OP_ASR = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_ROR = 4'd7,
		OP_TST = 4'd8,
		OP_NEG = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MUL = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} op_t;

	localparam int unsigned DATA_W = 32;

	// one operation item
	typedef struct packed {
		logic [3:0]        mode;
		logic [DATA_W-1:0] first_operand;
		logic [DATA_W-1:0] second_operand;
		logic              carry_in;
		logic              overflow_in;
	} in_t;

	// one result item
	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              write_enable;
		logic              negative_flag;
		logic              zero_flag;
		logic              carry_out;
		logic              overflow_out;
		logic              extra_cycle;
	} out_t;

endpackage

/* sv/thumb_register_alu.sv */
// Thumb register ALU: runs one of the sixteen format 4 operations per item.
// Input channel in_valid/in_ready carries in_item: opcode, Rd and Rs values,
// and the current C and V flags. Output channel out_valid/out_ready carries
// out_item: the value for Rd, its write enable, the new N Z C V flags and
// the mark for register-specified shifts.
// An item is captured in the input register, worked
// out by the ALU (shared adder, barrel shifter, 32x32 low-half multiplier)
// and held in the result register, where it is shown on the output.
// Throughput is one item per cycle while the receiver does not stall; the multiplier path sets the clock.
// When the receiver stalls, the result register holds its item and the
// input register may still take one more item; in_ready drops only when
// both are full and out_ready is low.
// Reset clears both valid bits; no result is shown until an item arrives.
module thumb_register_alu
	import thb_alu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	logic v_s1;
	in_t  item_s1;
	logic v_s2;
	out_t res_s2;
	out_t core_res;
	logic adv_s2;

	// stage handshake
	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	thb_alu_core u_core (
		.op_item  (item_s1),
		.res_item (core_res)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = res_s2;

endmodule

/* sv/thb_alu_core.sv */
module thb_alu_core
	import thb_alu_pkg::*;
(
	input  in_t  op_item,
	output out_t res_item
);

	op_t               op;
	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	logic [7:0]        amt;
	logic [4:0]        sh;
	logic              amt_zero;

	// shifter intermediates
	logic [DATA_W:0]       lsl_full;
	logic [DATA_W:0]       lsr_full;
	logic [DATA_W:0]       asr_full;
	logic [2*DATA_W-1:0]   ror_full;

	// shared adder
	logic [DATA_W-1:0] add_x;
	logic [DATA_W-1:0] add_y;
	logic              add_ci;
	logic [DATA_W:0]   add_sum;
	logic              add_v;

	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] r;
	logic              c;
	logic              v;

	assign op       = op_t'(op_item.mode);
	assign a        = op_item.first_operand;
	assign b        = op_item.second_operand;
	assign amt      = b[7:0];
	assign sh       = amt[4:0];
	assign amt_zero = (amt == 8'd0);

	// barrel shifts; for LSL, LSR and ASR the last bit shifted out is kept in the extra bit
	assign lsl_full = {1'b0, a} << sh;
	assign lsr_full = {a, 1'b0} >> sh;
	assign asr_full = $unsigned($signed({a, 1'b0}) >>> sh);
	assign ror_full = {a, a} >> sh;

	// operand select for the adder
	always_comb begin
		add_x  = a;
		add_y  = b;
		add_ci = op_item.carry_in;
		case (op)
			OP_SBC: add_y = ~b;
			OP_NEG: begin
				add_x  = '0;
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_CMP: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_CMN: add_ci = 1'b0;
			default: ;
		endcase
	end

	assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_ci};
	assign add_v   = (add_x[DATA_W-1] ^ add_sum[DATA_W-1])
		& (add_y[DATA_W-1] ^ add_sum[DATA_W-1]);

	// low half of the product
	assign prod = a * b;

	// result and carry/overflow select
	always_comb begin
		r = a;
		c = op_item.carry_in;
		v = op_item.overflow_in;
		case (op)
			OP_AND, OP_TST: r = a & b;
			OP_EOR:         r = a ^ b;
			OP_ORR:         r = a | b;
			OP_BIC:         r = a & ~b;
			OP_MVN:         r = ~b;
			OP_MUL: begin
				r = prod;
				c = 1'b0;
			end
			OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
				r = add_sum[DATA_W-1:0];
				c = add_sum[DATA_W];
				v = add_v;
			end
			OP_LSL: begin
				if (amt_zero) begin
					r = a;
				end else if (amt < 8'd32) begin
					r = lsl_full[DATA_W-1:0];
					c = lsl_full[DATA_W];
				end else if (amt == 8'd32) begin
					r = '0;
					c = a[0];
				end else begin
					r = '0;
					c = 1'b0;
				end
			end
			OP_LSR: begin
				if (amt_zero) begin
					r = a;
				end else if (amt < 8'd32) begin
					r = lsr_full[DATA_W:1];
					c = lsr_full[0];
				end else if (amt == 8'd32) begin
					r = '0;
					c = a[DATA_W-1];
				end else begin
					r = '0;
					c = 1'b0;
				end
			end
			OP_ASR: begin
				if (amt_zero) begin
					r = a;
				end else if (amt < 8'd32) begin
					r = asr_full[DATA_W:1];
					c = asr_full[0];
				end else begin
					r = {DATA_W{a[DATA_W-1]}};
					c = a[DATA_W-1];
				end
			end
			OP_ROR: begin
				// nonzero multiples of 32 leave the word as is, carry takes bit 31
				if (!amt_zero) begin
					r = ror_full[DATA_W-1:0];
					c = ror_full[DATA_W-1];
				end
			end
			default: r = a;
		endcase
	end

	// pack the result item
	always_comb begin
		res_item               = '0;
		res_item.result        = r;
		res_item.write_enable  = !(op inside {OP_TST, OP_CMP, OP_CMN});
		res_item.negative_flag = r[DATA_W-1];
		res_item.zero_flag     = (r == '0);
		res_item.carry_out     = c;
		res_item.overflow_out  = v;
		res_item.extra_cycle   = (op inside {OP_LSL, OP_LSR, OP_ASR, OP_ROR});
	end

endmodule

/* sv/thb_alu_chk.sv */
module thb_alu_chk
	import thb_alu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_item,
	input logic out_valid,
	input logic out_ready,
	input out_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// an accepted item is followed by out_valid once it has passed the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted item did not reach the output");

	// input side stalls only behind a full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// zero result cannot be negative
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.zero_flag |-> !out_item.negative_flag)
		else $error("n and z both set");

endmodule

bind thumb_register_alu thb_alu_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
